// ----- src/dcp_pkg.sv -----
// shared types, constants and table builder functions of the damped cosine pulse sampler
// no dependencies

package dcp_pkg;

    // table sizes and pulse limit
    localparam int COS_BITS_DEF = 10;
    localparam int EXP_BITS_DEF = 10;
    localparam int PULSE_MAX    = 2048;

    // fixed-point constants in q2.30
    localparam longint ONE_Q30     = 64'd1 << 30;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint INV_E_Q30   = 64'd395007542;
    localparam int     EXP_RANGE_LOG2 = 4;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [1:0] REG_DECAY_STEP   = 2'd1;
    localparam logic [1:0] REG_GAIN         = 2'd2;
    localparam logic [1:0] REG_PULSE_LENGTH = 2'd3;

    // per stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

    // clamp a q2.30 value to 0..1 and round to q15
    function automatic int q30_to_q15(longint v);
        longint c;
        c = v;
        if (c < 0) c = 0;
        if (c > ONE_Q30) c = ONE_Q30;
        return int'((c + 64'd16384) >>> 15);
    endfunction

    // cosine series for 0 <= th < pi/2, q2.30
    function automatic longint taylor_cos(longint th);
        longint t2;
        longint term;
        longint sum;
        t2   = (th * th) >>> 30;
        term = ONE_Q30;
        sum  = term;
        term = ((term * t2) >>> 30) / 2;   sum = sum - term;
        term = ((term * t2) >>> 30) / 12;  sum = sum + term;
        term = ((term * t2) >>> 30) / 30;  sum = sum - term;
        term = ((term * t2) >>> 30) / 56;  sum = sum + term;
        term = ((term * t2) >>> 30) / 90;  sum = sum - term;
        term = ((term * t2) >>> 30) / 132; sum = sum + term;
        return sum;
    endfunction

    // sine series for 0 <= th < pi/2, q2.30
    function automatic longint taylor_sin(longint th);
        longint t2;
        longint term;
        longint sum;
        t2   = (th * th) >>> 30;
        term = th;
        sum  = term;
        term = ((term * t2) >>> 30) / 6;   sum = sum - term;
        term = ((term * t2) >>> 30) / 20;  sum = sum + term;
        term = ((term * t2) >>> 30) / 42;  sum = sum - term;
        term = ((term * t2) >>> 30) / 72;  sum = sum + term;
        term = ((term * t2) >>> 30) / 110; sum = sum - term;
        term = ((term * t2) >>> 30) / 156; sum = sum + term;
        return sum;
    endfunction

    // cosine table entry k, q15 in -32768..32768
    function automatic int cos_entry(int k, int bits);
        int     sub;
        int     q;
        longint r;
        longint th;
        int     mag;
        sub = bits - 2;
        q   = (k >> sub) & 3;
        r   = longint'(k & ((1 << sub) - 1));
        th  = (r * HALF_PI_Q30) >>> sub;
        if (q == 0 || q == 2) mag = q30_to_q15(taylor_cos(th));
        else                  mag = q30_to_q15(taylor_sin(th));
        return (q == 1 || q == 2) ? -mag : mag;
    endfunction

    // exponential table entry k, exp(-16k/2^bits) in q15
    function automatic int exp_entry(int k, int bits);
        longint y;
        longint n;
        longint f;
        longint term;
        longint sum;
        longint v;
        y    = longint'(k) << (30 + EXP_RANGE_LOG2 - bits);
        n    = y >>> 30;
        f    = y & (ONE_Q30 - 1);
        term = ONE_Q30;
        sum  = ONE_Q30;
        term = ((term * f) >>> 30) / 1;  sum = sum - term;
        term = ((term * f) >>> 30) / 2;  sum = sum + term;
        term = ((term * f) >>> 30) / 3;  sum = sum - term;
        term = ((term * f) >>> 30) / 4;  sum = sum + term;
        term = ((term * f) >>> 30) / 5;  sum = sum - term;
        term = ((term * f) >>> 30) / 6;  sum = sum + term;
        term = ((term * f) >>> 30) / 7;  sum = sum - term;
        term = ((term * f) >>> 30) / 8;  sum = sum + term;
        term = ((term * f) >>> 30) / 9;  sum = sum - term;
        term = ((term * f) >>> 30) / 10; sum = sum + term;
        term = ((term * f) >>> 30) / 11; sum = sum - term;
        term = ((term * f) >>> 30) / 12; sum = sum + term;
        if (sum < 0) sum = 0;
        if (sum > ONE_Q30) sum = ONE_Q30;
        v = sum;
        for (int i = 0; i < 16; i++) begin
            if (longint'(i) < n) v = (v * INV_E_Q30 + (64'd1 << 29)) >>> 30;
        end
        return q30_to_q15(v);
    endfunction

endpackage

// ----- src/dcp_time.sv -----
// time wrap and phase / decay argument multipliers (pipeline stages 1 and 2)
// depends on dcp_pkg

module dcp_time #(
    parameter int COS_TABLE_BITS = dcp_pkg::COS_BITS_DEF,
    parameter int EXP_TABLE_BITS = dcp_pkg::EXP_BITS_DEF
) (
    input  logic                      i_clk,
    input  dcp_pkg::t_pipe_en         i_en,
    input  logic [11:0]               i_sample_index,
    input  logic [31:0]               i_phase_step,
    input  logic [31:0]               i_decay_step,
    input  logic [11:0]               i_pulse_length,
    output logic [COS_TABLE_BITS-1:0] o_cos_idx,
    output logic [EXP_TABLE_BITS-1:0] o_exp_idx,
    output logic                      o_exp_ovf
);
    import dcp_pkg::*;

    logic [11:0]               len;
    logic [11:0]               n_t;
    logic [11:0]               r_t;
    logic [43:0]               prod_p;
    logic [43:0]               prod_d;
    logic [COS_TABLE_BITS-1:0] r_cos_idx;
    logic [EXP_TABLE_BITS-1:0] r_exp_idx;
    logic                      r_exp_ovf;

    // clamp the pulse length and subtract it once
    always_comb begin
        if ({5'd0, i_pulse_length} > 17'(PULSE_MAX)) len = 12'(PULSE_MAX);
        else                                         len = i_pulse_length;
        n_t = (i_sample_index >= len) ? (i_sample_index - len) : i_sample_index;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) r_t <= n_t;
    end

    // phase and decay arguments
    assign prod_p = {32'd0, r_t} * {12'd0, i_phase_step};
    assign prod_d = {32'd0, r_t} * {12'd0, i_decay_step};

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_cos_idx <= prod_p[31:32-COS_TABLE_BITS];
            r_exp_idx <= prod_d[35:36-EXP_TABLE_BITS];
            r_exp_ovf <= |prod_d[43:36];
        end
    end

    assign o_cos_idx = r_cos_idx;
    assign o_exp_idx = r_exp_idx;
    assign o_exp_ovf = r_exp_ovf;

endmodule

// ----- src/dcp_rom.sv -----
// cosine and exponential lookup tables with registered reads (pipeline stage 3)
// depends on dcp_pkg

module dcp_rom #(
    parameter int COS_TABLE_BITS = dcp_pkg::COS_BITS_DEF,
    parameter int EXP_TABLE_BITS = dcp_pkg::EXP_BITS_DEF
) (
    input  logic                      i_clk,
    input  dcp_pkg::t_pipe_en         i_en,
    input  logic [COS_TABLE_BITS-1:0] i_cos_idx,
    input  logic [EXP_TABLE_BITS-1:0] i_exp_idx,
    input  logic                      i_exp_ovf,
    output logic signed [16:0]        o_cos,
    output logic [15:0]               o_exp
);
    import dcp_pkg::*;

    localparam int COS_DEPTH = 1 << COS_TABLE_BITS;
    localparam int EXP_DEPTH = 1 << EXP_TABLE_BITS;

    typedef logic signed [16:0] t_cos_tab [COS_DEPTH];
    typedef logic [15:0]        t_exp_tab [EXP_DEPTH];

    function automatic t_cos_tab build_cos();
        t_cos_tab tab;
        for (int k = 0; k < COS_DEPTH; k++) tab[k] = 17'(cos_entry(k, COS_TABLE_BITS));
        return tab;
    endfunction

    function automatic t_exp_tab build_exp();
        t_exp_tab tab;
        for (int k = 0; k < EXP_DEPTH; k++) tab[k] = 16'(exp_entry(k, EXP_TABLE_BITS));
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos();
    localparam t_exp_tab EXP_TAB = build_exp();

    logic signed [16:0] r_cos;
    logic [15:0]        r_exp;

    // table reads, exponential forced to zero past its range
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_cos <= COS_TAB[i_cos_idx];
            r_exp <= i_exp_ovf ? 16'd0 : EXP_TAB[i_exp_idx];
        end
    end

    assign o_cos = r_cos;
    assign o_exp = r_exp;

endmodule

// ----- src/dcp_scale.sv -----
// product of cosine, exponential and gain, rounding and saturation (stages 4 to 6)
// depends on dcp_pkg

module dcp_scale (
    input  logic               i_clk,
    input  dcp_pkg::t_pipe_en  i_en,
    input  logic signed [16:0] i_cos,
    input  logic [15:0]        i_exp,
    input  logic [15:0]        i_gain,
    output logic [15:0]        o_sample_value
);
    import dcp_pkg::*;

    logic signed [33:0] ce_full;
    logic signed [31:0] r_ce;
    logic signed [48:0] prod_full;
    logic signed [46:0] r_prod;
    logic               neg;
    logic [46:0]        mag;
    logic [46:0]        mag_rnd;
    logic [16:0]        mag_q;
    logic [15:0]        n_val;
    logic [15:0]        r_val;

    // cosine times exponential
    assign ce_full = i_cos * $signed({1'b0, i_exp});

    always_ff @(posedge i_clk) begin
        if (i_en.s4) r_ce <= ce_full[31:0];
    end

    // times gain
    assign prod_full = r_ce * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_en.s5) r_prod <= prod_full[46:0];
    end

    // round half away from zero to q15 and saturate
    always_comb begin
        neg     = r_prod[46];
        mag     = neg ? 47'(-r_prod) : 47'(r_prod);
        mag_rnd = mag + (47'd1 << 29);
        mag_q   = mag_rnd[46:30];
        if (neg) n_val = (mag_q > 17'd32768) ? 16'h8000 : 16'(-mag_q);
        else     n_val = (mag_q > 17'd32767) ? 16'h7FFF : mag_q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) r_val <= n_val;
    end

    assign o_sample_value = r_val;

endmodule

// ----- src/damped_cosine_pulse_sample.sv -----
// Damped cosine pulse sampler. Takes one sample index per request on the slave stream and
// returns cos(2*pi*t*phase_step) * exp(-t*decay_step) * gain as a signed Q1.15 sample on the
// master stream, with t the index less the pulse length once the index reaches it. The block
// takes one request per clock while the master side is ready; wrap, argument multiply,
// table lookup, two product multiplies and round/saturate each hold one register stage.
// A stall on the master side holds the stages, and requests are still taken while
// empty stages remain. Configuration writes take effect at once and belong between runs.
// depends on dcp_pkg, dcp_time, dcp_rom, dcp_scale

module damped_cosine_pulse_sample #(
    parameter int COS_TABLE_BITS = dcp_pkg::COS_BITS_DEF,
    parameter int EXP_TABLE_BITS = dcp_pkg::EXP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] sample_index, [15:12] zero
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] sample_value
);
    import dcp_pkg::*;

    logic [31:0]               r_phase_step;
    logic [31:0]               r_decay_step;
    logic [15:0]               r_gain;
    logic [11:0]               r_pulse_length;
    logic [6:1]                r_vld;
    logic [7:1]                adv;
    t_pipe_en                  en;
    logic [COS_TABLE_BITS-1:0] cos_idx;
    logic [EXP_TABLE_BITS-1:0] exp_idx;
    logic                      exp_ovf;
    logic signed [16:0]        cos_val;
    logic [15:0]               exp_val;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= 32'd6442451;
            r_decay_step   <= 32'd20239557;
            r_gain         <= 16'd16384;
            r_pulse_length <= 12'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                REG_DECAY_STEP:   r_decay_step   <= i_cfg_data;
                REG_GAIN:         r_gain         <= i_cfg_data[15:0];
                REG_PULSE_LENGTH: r_pulse_length <= i_cfg_data[11:0];
                default:          r_gain         <= r_gain;
            endcase
        end
    end

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        adv[7] = i_m_tready;
        for (int k = 6; k >= 1; k--) adv[k] = !r_vld[k] || adv[k+1];
        en.s1 = adv[1];
        en.s2 = adv[2];
        en.s3 = adv[3];
        en.s4 = adv[4];
        en.s5 = adv[5];
        en.s6 = adv[6];
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) r_vld[1] <= i_s_tvalid;
            for (int k = 2; k <= 6; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_s_tready = adv[1];
    assign o_m_tvalid = r_vld[6];

    dcp_time #(
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_time (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_sample_index (i_s_tdata[11:0]),
        .i_phase_step   (r_phase_step),
        .i_decay_step   (r_decay_step),
        .i_pulse_length (r_pulse_length),
        .o_cos_idx      (cos_idx),
        .o_exp_idx      (exp_idx),
        .o_exp_ovf      (exp_ovf)
    );

    dcp_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_rom (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_cos_idx (cos_idx),
        .i_exp_idx (exp_idx),
        .i_exp_ovf (exp_ovf),
        .o_cos     (cos_val),
        .o_exp     (exp_val)
    );

    dcp_scale u_scale (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_cos          (cos_val),
        .i_exp          (exp_val),
        .i_gain         (r_gain),
        .o_sample_value (o_m_tdata)
    );

endmodule

// ----- src/dcp_checker.sv -----
// port-level checks of the damped cosine pulse sampler, bound to the top level
// depends on damped_cosine_pulse_sample

module dcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // with no result waiting every stage can move, so a request is taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("request refused with empty output");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a taken request comes out as a valid result when the master side does not stall
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_m_tready) ##1 i_m_tready ##1 i_m_tready
        ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready |=> o_m_tvalid)
        else $error("result missing after six cycles");

endmodule

bind damped_cosine_pulse_sample dcp_checker u_dcp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
